// ----- hdl/hc20_pkg.sv -----
// HChaCha20 subkey block: shared widths, register indexes, constants and the
// ARX step function used by every pipeline stage. No dependencies.
package hc20_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned FIELD_W     = 64;
	localparam int unsigned CFG_IDX_W   = 8;
	localparam int unsigned KEY_REGS    = 4;
	localparam int unsigned STATE_WORDS = 16;
	localparam int unsigned STEPS_PER_DR = 8;
	localparam int unsigned DOUBLE_ROUNDS_DEF = 10;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);

	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

	localparam int unsigned ROT_0 = 16;
	localparam int unsigned ROT_1 = 12;
	localparam int unsigned ROT_2 = 8;
	localparam int unsigned ROT_3 = 7;

	// quarter-round step codes
	localparam logic [1:0] STEP_A_D16 = 2'd0;
	localparam logic [1:0] STEP_C_B12 = 2'd1;
	localparam logic [1:0] STEP_A_D8  = 2'd2;
	localparam logic [1:0] STEP_C_B7  = 2'd3;

	typedef logic [STATE_WORDS-1:0][WORD_W-1:0] state_t;

	function automatic logic [WORD_W-1:0] rotl32(logic [WORD_W-1:0] v, int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	// one add/xor/rotate step of all four quarter rounds of a half round
	function automatic state_t arx_step(state_t x, logic diag, logic [1:0] step);
		state_t     y;
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
		y = x;
		for (int q = 0; q < 4; q++) begin
			a = 4'(q);
			b = diag ? 4'(4 + ((q + 1) % 4)) : 4'(4 + q);
			c = diag ? 4'(8 + ((q + 2) % 4)) : 4'(8 + q);
			d = diag ? 4'(12 + ((q + 3) % 4)) : 4'(12 + q);
			unique case (step)
				STEP_A_D16: begin
					y[a] = y[a] + y[b];
					y[d] = rotl32(y[d] ^ y[a], ROT_0);
				end
				STEP_C_B12: begin
					y[c] = y[c] + y[d];
					y[b] = rotl32(y[b] ^ y[c], ROT_1);
				end
				STEP_A_D8: begin
					y[a] = y[a] + y[b];
					y[d] = rotl32(y[d] ^ y[a], ROT_2);
				end
				STEP_C_B7: begin
					y[c] = y[c] + y[d];
					y[b] = rotl32(y[b] ^ y[c], ROT_3);
				end
				default: begin
					y = x;
				end
			endcase
		end
		return y;
	endfunction

endpackage

// ----- hdl/hc20_nonce_if.sv -----
// Nonce input channel: valid/ready plus the two 64-bit nonce fields.
// Depends on hc20_pkg.
interface hc20_nonce_if import hc20_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] nonce_low;
	logic [FIELD_W-1:0] nonce_high;

	modport source (output valid, output nonce_low, output nonce_high, input ready);
	modport sink   (input valid, input nonce_low, input nonce_high, output ready);
endinterface

// ----- hdl/hc20_subkey_if.sv -----
// Subkey output channel: valid/ready plus the four 64-bit subkey fields.
// Depends on hc20_pkg.
interface hc20_subkey_if import hc20_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] subkey_0;
	logic [FIELD_W-1:0] subkey_1;
	logic [FIELD_W-1:0] subkey_2;
	logic [FIELD_W-1:0] subkey_3;

	modport source (output valid, output subkey_0, output subkey_1, output subkey_2,
		output subkey_3, input ready);
	modport sink   (input valid, input subkey_0, input subkey_1, input subkey_2,
		input subkey_3, output ready);
endinterface

// ----- hdl/hc20_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on hc20_pkg.
interface hc20_cfg_if import hc20_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [FIELD_W-1:0]   data;

	modport source (output valid, output idx, output data, input ready);
	modport sink   (input valid, input idx, input data, output ready);
endinterface

// ----- hdl/hchacha20_subkey.sv -----
// HChaCha20 subkey derivation, fully pipelined, one ARX step per stage.
// Depends on hc20_pkg, hc20_nonce_if, hc20_subkey_if, hc20_cfg_if.
//
//   channel  dir  beat contents
//   nonce    in   nonce_low, nonce_high
//   subkey   out  subkey_0 .. subkey_3 (state words 0-3, 12-15)
//   cfg      in   idx, data (key_word_0..3 at idx 0..3, others ignored)
//
// Every quarter-round add/xor/rotate step of all four lanes occupies one
// register stage.
// One nonce beat is taken per cycle while the output is not stalled.
// A stalled output beat freezes the whole pipeline; nonce.ready drops with it.
// arst_n clears the key registers and all stage valid bits.
module hchacha20_subkey import hc20_pkg::*; #(
	parameter int unsigned DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hc20_nonce_if.sink    nonce,
	hc20_subkey_if.source subkey,
	hc20_cfg_if.sink      cfg
);

	localparam int unsigned STAGES = STEPS_PER_DR * DOUBLE_ROUNDS;

	logic [FIELD_W-1:0] key_q [KEY_REGS];
	state_t             init_state;
	logic               stall;
	state_t             pipe_state_s [STAGES];
	logic [STAGES-1:0]  pipe_vld_s;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_REGS; i++) key_q[i] <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.idx)
				REG_KEY_WORD_0: key_q[0] <= cfg.data;
				REG_KEY_WORD_1: key_q[1] <= cfg.data;
				REG_KEY_WORD_2: key_q[2] <= cfg.data;
				REG_KEY_WORD_3: key_q[3] <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		init_state[0] = SIGMA_0;
		init_state[1] = SIGMA_1;
		init_state[2] = SIGMA_2;
		init_state[3] = SIGMA_3;
		for (int i = 0; i < KEY_REGS; i++) begin
			init_state[4 + 2 * i] = key_q[i][WORD_W-1:0];
			init_state[5 + 2 * i] = key_q[i][FIELD_W-1:WORD_W];
		end
		init_state[12] = nonce.nonce_low[WORD_W-1:0];
		init_state[13] = nonce.nonce_low[FIELD_W-1:WORD_W];
		init_state[14] = nonce.nonce_high[WORD_W-1:0];
		init_state[15] = nonce.nonce_high[FIELD_W-1:WORD_W];
	end

	assign stall       = pipe_vld_s[STAGES-1] && !subkey.ready;
	assign nonce.ready = !stall;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [1:0] STEP = 2'(k % 4);
		localparam logic       DIAG = 1'((k / 4) % 2);

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pipe_vld_s[k] <= 1'b0;
				end else if (!stall) begin
					pipe_vld_s[k] <= nonce.valid;
				end
			end

			always_ff @(posedge clk) begin
				if (!stall) begin
					pipe_state_s[k] <= arx_step(init_state, DIAG, STEP);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pipe_vld_s[k] <= 1'b0;
				end else if (!stall) begin
					pipe_vld_s[k] <= pipe_vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (!stall) begin
					pipe_state_s[k] <= arx_step(pipe_state_s[k-1], DIAG, STEP);
				end
			end
		end
	end

	assign subkey.valid    = pipe_vld_s[STAGES-1];
	assign subkey.subkey_0 = {pipe_state_s[STAGES-1][1], pipe_state_s[STAGES-1][0]};
	assign subkey.subkey_1 = {pipe_state_s[STAGES-1][3], pipe_state_s[STAGES-1][2]};
	assign subkey.subkey_2 = {pipe_state_s[STAGES-1][13], pipe_state_s[STAGES-1][12]};
	assign subkey.subkey_3 = {pipe_state_s[STAGES-1][15], pipe_state_s[STAGES-1][14]};

`ifndef ASSERT_OFF
	a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!nonce.ready |-> subkey.valid)
		else $error("nonce.ready low without a waiting output beat");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		nonce.valid && nonce.ready |=> pipe_vld_s[0])
		else $error("accepted nonce beat missing from first stage");

	a_stall_holds_first: assert property (@(posedge clk) disable iff (!arst_n)
		stall && pipe_vld_s[0] |=> pipe_vld_s[0] && $stable(pipe_state_s[0]))
		else $error("first stage changed during stall");

	a_last_feeds_out: assert property (@(posedge clk) disable iff (!arst_n)
		!stall && pipe_vld_s[STAGES-2] |=> subkey.valid)
		else $error("beat lost before output stage");
`endif

endmodule
